### rtl/c_subset_lexer_macros.svh
// Assertion helpers used by the lexer top level.
`ifndef C_SUBSET_LEXER_MACROS_SVH
`define C_SUBSET_LEXER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CLX_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CLX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/clx_pkg.sv
package clx_pkg;

  // Token classes as carried in a result beat
  typedef enum logic [2:0] {
    TOK_KEYWORD  = 3'd0,
    TOK_CONSTANT = 3'd1,
    TOK_IDENT    = 3'd2,
    TOK_OPERATOR = 3'd3,
    TOK_HEADER   = 3'd4,
    TOK_STRING   = 3'd5,
    TOK_SPECIAL  = 3'd6,
    TOK_CHARLIT  = 3'd7
  } tok_class_t;

  localparam logic [3:0]  NOT_KEYWORD = 4'd9;
  localparam logic [15:0] LEN_MAX     = 16'hFFFF;

  // Result queue: room for one beat's worth of records plus slack
  localparam int QUEUE_DEPTH = 4;

  // Characters with a meaning of their own
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_USCORE  = 8'h5F;

  // Keyword table, zero padded to the longest keyword
  localparam int KW_COUNT   = 9;
  localparam int KW_MAX_LEN = 6;
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
    '{"f", "l", "o", "a", "t", 8'h00},
    '{"d", "o", "u", "b", "l", "e"},
    '{"c", "h", "a", "r", 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00},
    '{"p", "r", "i", "n", "t", "f"},
    '{"r", "e", "t", "u", "r", "n"}
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd5, 3'd6, 3'd4, 3'd2,
                                              3'd5, 3'd4, 3'd6, 3'd6};

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    tok_class_t  token_class;
    logic [3:0]  keyword_id;
    logic [15:0] start_pos;
    logic [15:0] token_length;
    logic [7:0]  symbol_byte;
    logic        last_of_run;
  } out_t;

  // Records handed together, in the same cycle, from the lexer core to the result queue
  typedef struct packed {
    logic [1:0] count;
    out_t       rec0;
    out_t       rec1;
  } push_t;

  typedef struct packed {
    logic [2:0] fill;
  } q_stat_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_word_byte(input logic [7:0] b);
    return is_digit(b) || ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) ||
           (b == CH_USCORE);
  endfunction

  function automatic logic is_operator(input logic [7:0] b);
    logic hit;
    unique case (b)
      "+", "-", "*", "/", "%", "<", ">", "=", "!", "&", "|": hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic is_special(input logic [7:0] b);
    logic hit;
    unique case (b)
      "(", ")", "[", "]", "{", "}", ",", ";": hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic out_t make_rec(input tok_class_t cls, input logic [3:0] kw,
                                    input logic [15:0] start, input logic [15:0] len,
                                    input logic [7:0] sym);
    out_t r;
    r.token_class  = cls;
    r.keyword_id   = kw;
    r.start_pos    = start;
    r.token_length = len;
    r.symbol_byte  = sym;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

endpackage

### rtl/clx_core.sv
module clx_core #(
  parameter int POSITION_BITS = 16,
  parameter int KEYWORD_CHARS = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  clx_pkg::in_t   beat,
  output clx_pkg::push_t push
);

  localparam int KC_IDX_W = $clog2(KEYWORD_CHARS);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_HEADER,
    MODE_STRING,
    MODE_CHAR
  } mode_t;

  mode_t                    mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] start_r, start_nxt;
  logic [15:0]              len_r, len_nxt;
  logic                     dot_r, dot_nxt;
  logic [7:0]               kw_chars_r [KEYWORD_CHARS];

  logic                kw_we;
  logic [KC_IDX_W-1:0] kw_wa;
  logic [7:0]          b;
  logic [15:0]         len_grow;
  logic                kw_hit;
  logic [3:0]          kw_idx;
  clx_pkg::out_t       word_rec;
  logic                lead_vld, tail_vld;
  clx_pkg::out_t       lead_rec, tail_rec;

  assign b        = beat.in_byte;
  assign len_grow = (len_r == clx_pkg::LEN_MAX) ? len_r : len_r + 16'd1;

  // Keyword compare against the stored leading characters, all entries in parallel
  always_comb begin
    logic mism;
    kw_hit = 1'b0;
    kw_idx = clx_pkg::NOT_KEYWORD;
    for (int i = clx_pkg::KW_COUNT - 1; i >= 0; i--) begin
      mism = (len_r != 16'(clx_pkg::KW_LEN[i]));
      for (int j = 0; j < clx_pkg::KW_MAX_LEN; j++) begin
        if ((j < int'(clx_pkg::KW_LEN[i])) && (kw_chars_r[j] != clx_pkg::KW_TEXT[i][j]))
          mism = 1'b1;
      end
      if (!mism) begin
        kw_hit = 1'b1;
        kw_idx = 4'(i);
      end
    end
  end

  // Finished word: keyword, constant or identifier
  always_comb begin
    if (kw_hit)
      word_rec = clx_pkg::make_rec(clx_pkg::TOK_KEYWORD, kw_idx, 16'(start_r), len_r, 8'h00);
    else if (clx_pkg::is_digit(kw_chars_r[0]))
      word_rec = clx_pkg::make_rec(clx_pkg::TOK_CONSTANT, clx_pkg::NOT_KEYWORD,
                                   16'(start_r), len_r, 8'h00);
    else
      word_rec = clx_pkg::make_rec(clx_pkg::TOK_IDENT, clx_pkg::NOT_KEYWORD,
                                   16'(start_r), len_r, 8'h00);
  end

  // Next-state and record selection for the accepted beat
  always_comb begin
    logic idle_pass;
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    dot_nxt   = dot_r;
    kw_we     = 1'b0;
    kw_wa     = len_r[KC_IDX_W-1:0];
    lead_vld  = 1'b0;
    tail_vld  = 1'b0;
    lead_rec  = word_rec;
    tail_rec  = word_rec;
    idle_pass = 1'b0;
    if (fire) begin
      if (beat.end_of_input) begin
        // flush whatever token is open; position holds
        mode_nxt = MODE_IDLE;
        unique case (mode_r)
          MODE_WORD: lead_vld = 1'b1;
          MODE_HEADER: begin
            lead_vld = 1'b1;
            lead_rec = clx_pkg::make_rec(clx_pkg::TOK_HEADER, clx_pkg::NOT_KEYWORD,
                                         16'(start_r), len_r, 8'h00);
          end
          MODE_STRING: begin
            lead_vld = 1'b1;
            lead_rec = clx_pkg::make_rec(clx_pkg::TOK_STRING, clx_pkg::NOT_KEYWORD,
                                         16'(start_r), len_r, 8'h00);
          end
          MODE_CHAR: begin
            lead_vld = 1'b1;
            lead_rec = clx_pkg::make_rec(clx_pkg::TOK_CHARLIT, clx_pkg::NOT_KEYWORD,
                                         16'(start_r), len_r, 8'h00);
          end
          default: lead_vld = 1'b0;
        endcase
      end else begin
        pos_nxt = pos_r + POSITION_BITS'(1);
        unique case (mode_r)
          MODE_HEADER: begin
            if (b == clx_pkg::CH_NEWLINE) begin
              lead_vld = 1'b1;
              lead_rec = clx_pkg::make_rec(clx_pkg::TOK_HEADER, clx_pkg::NOT_KEYWORD,
                                           16'(start_r), len_r, 8'h00);
              mode_nxt = MODE_IDLE;
            end else begin
              len_nxt = len_grow;
            end
          end
          MODE_STRING: begin
            len_nxt = len_grow;
            if (b == clx_pkg::CH_DQUOTE) begin
              lead_vld = 1'b1;
              lead_rec = clx_pkg::make_rec(clx_pkg::TOK_STRING, clx_pkg::NOT_KEYWORD,
                                           16'(start_r), len_grow, 8'h00);
              mode_nxt = MODE_IDLE;
            end
          end
          MODE_CHAR: begin
            len_nxt = len_grow;
            if (b == clx_pkg::CH_SQUOTE) begin
              lead_vld = 1'b1;
              lead_rec = clx_pkg::make_rec(clx_pkg::TOK_CHARLIT, clx_pkg::NOT_KEYWORD,
                                           16'(start_r), len_grow, 8'h00);
              mode_nxt = MODE_IDLE;
            end
          end
          MODE_WORD: begin
            if (clx_pkg::is_word_byte(b) || ((b == clx_pkg::CH_DOT) && !dot_r)) begin
              kw_we   = (len_r < 16'(KEYWORD_CHARS));
              dot_nxt = dot_r || (b == clx_pkg::CH_DOT);
              len_nxt = len_grow;
            end else begin
              // word ends; the byte is then seen as in idle
              lead_vld  = 1'b1;
              mode_nxt  = MODE_IDLE;
              idle_pass = 1'b1;
            end
          end
          default: idle_pass = 1'b1;
        endcase

        if (idle_pass) begin
          if (clx_pkg::is_word_byte(b)) begin
            mode_nxt  = MODE_WORD;
            start_nxt = pos_r;
            len_nxt   = 16'd1;
            dot_nxt   = 1'b0;
            kw_we     = 1'b1;
            kw_wa     = '0;
          end else if (clx_pkg::is_operator(b)) begin
            tail_vld = 1'b1;
            tail_rec = clx_pkg::make_rec(clx_pkg::TOK_OPERATOR, clx_pkg::NOT_KEYWORD,
                                         16'(pos_r), 16'd1, b);
          end else if (b == clx_pkg::CH_HASH) begin
            mode_nxt  = MODE_HEADER;
            start_nxt = pos_r;
            len_nxt   = 16'd1;
            dot_nxt   = 1'b0;
          end else if (b == clx_pkg::CH_DQUOTE) begin
            mode_nxt  = MODE_STRING;
            start_nxt = pos_r;
            len_nxt   = 16'd1;
            dot_nxt   = 1'b0;
          end else if (clx_pkg::is_special(b)) begin
            tail_vld = 1'b1;
            tail_rec = clx_pkg::make_rec(clx_pkg::TOK_SPECIAL, clx_pkg::NOT_KEYWORD,
                                         16'(pos_r), 16'd1, b);
          end else if (b == clx_pkg::CH_SQUOTE) begin
            mode_nxt  = MODE_CHAR;
            start_nxt = pos_r;
            len_nxt   = 16'd1;
            dot_nxt   = 1'b0;
          end
        end
      end
    end
  end

  // Pack records in order and mark the last one of the beat
  always_comb begin
    push = '0;
    if (lead_vld) begin
      push.rec0             = lead_rec;
      push.rec1             = tail_rec;
      push.count            = tail_vld ? 2'd2 : 2'd1;
      push.rec0.last_of_run = !tail_vld;
      push.rec1.last_of_run = 1'b1;
    end else if (tail_vld) begin
      push.rec0             = tail_rec;
      push.rec0.last_of_run = 1'b1;
      push.count            = 2'd1;
    end
  end

  // Lexer state; the character store has no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
      dot_r   <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      dot_r   <= dot_nxt;
      if (kw_we)
        kw_chars_r[kw_wa] <= b;
    end
  end

endmodule

### rtl/clx_outq.sv
module clx_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  clx_pkg::push_t    push,
  input  logic              out_ready,
  output logic              out_valid,
  output clx_pkg::out_t     out_data,
  output logic              room,
  output clx_pkg::q_stat_t  stat
);

  localparam int PTR_W = $clog2(clx_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(clx_pkg::QUEUE_DEPTH + 1);

  clx_pkg::out_t    q_r [clx_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] wr_next_slot;
  logic             pop;

  assign out_valid    = (cnt_r != '0);
  assign out_data     = q_r[rd_r];
  assign pop          = out_valid && out_ready;
  // take a beat only when two records fit
  assign room         = (cnt_r <= CNT_W'(clx_pkg::QUEUE_DEPTH - 2));
  assign stat.fill    = 3'(cnt_r);
  assign wr_next_slot = wr_r + PTR_W'(1);

  always_comb begin
    wr_nxt  = wr_r + PTR_W'(push.count);
    rd_nxt  = pop ? rd_r + PTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + CNT_W'(push.count) - CNT_W'(pop);
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Record storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0)
      q_r[wr_r] <= push.rec0;
    if (push.count == 2'd2)
      q_r[wr_next_slot] <= push.rec1;
  end

endmodule

### rtl/c_subset_lexer.sv
// Channel  Ports                         Beat
// -------  ----------------------------  ---------------------------------
// input    in_valid, in_ready, in_data   one source byte or end-of-input
// result   out_valid, out_ready, out_data one token record
//
// One input beat is taken per cycle while in_ready is high; each beat yields
// zero, one or two records. A beat is decoded in the cycle it is taken and its
// records sit in a four-entry result queue that drains one record per cycle
// while out_ready is high. in_ready drops while fewer than two entries are
// free, so only runs of two-record beats or a stalled result side slow the input.
// rst_n is synchronous; after reset the lexer is idle at position zero.
`include "c_subset_lexer_macros.svh"

module c_subset_lexer #(
  parameter int POSITION_BITS = 16,
  parameter int KEYWORD_CHARS = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  clx_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output clx_pkg::out_t out_data
);

  logic             in_fire;
  clx_pkg::push_t   push;
  clx_pkg::q_stat_t q_stat;

  assign in_fire = in_valid && in_ready;

  // Byte decode and lexer state
  clx_core #(
    .POSITION_BITS(POSITION_BITS),
    .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (in_fire),
    .beat (in_data),
    .push (push)
  );

  // Result queue
  clx_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data),
    .room     (in_ready),
    .stat     (q_stat)
  );

  // Checks
  `CLX_ASSERT_SAME(a_push_on_fire, clk, rst_n, push.count != 2'd0, in_fire, "records pushed without an input beat")
  `CLX_ASSERT_SAME(a_pair_not_eoi, clk, rst_n, push.count == 2'd2, !in_data.end_of_input, "end of input gave two records")
  `CLX_ASSERT_SAME(a_fill_bound, clk, rst_n, 1'b1, q_stat.fill <= 3'(clx_pkg::QUEUE_DEPTH), "result queue overfilled")
  `CLX_ASSERT_NEXT(a_run_follows, clk, rst_n, out_valid && out_ready && !out_data.last_of_run, out_valid, "record run cut short")

endmodule

### test/tb_top.sv
module tb_top;
  import clx_pkg::*;

  typedef enum logic [2:0] {LX_IDLE, LX_WORD, LX_HEADER, LX_STRING, LX_CHAR} lex_mode_e;

  // Character pools for building source text
  localparam string LETTERS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string DIGITS  = "0123456789";
  localparam string GAPS    = " \t\n\r:?~$@\\^";

  // Token predictor plus the queue of records still owed by the lexer
  class lex_scoreboard;
    localparam string OP_CHARS      = "+-*/%<>=!&|";
    localparam string SPECIAL_CHARS = "()[]{},;";

    lex_mode_e   mode;
    logic [15:0] position;
    logic [15:0] tok_start;
    logic [15:0] tok_len;
    bit          dot_seen;
    logic [7:0]  word_head [KW_MAX_LEN];
    out_t        token_q [$];
    int          errors;

    function new();
      mode      = LX_IDLE;
      position  = '0;
      tok_start = '0;
      tok_len   = '0;
      dot_seen  = 1'b0;
      errors    = 0;
    endfunction

    function int pending();
      return token_q.size();
    endfunction

    function bit in_text(string set, logic [7:0] b);
      for (int i = 0; i < set.len(); i++)
        if (set[i] == b) return 1'b1;
      return 1'b0;
    endfunction

    function bit digit_char(logic [7:0] b);
      return (b >= "0") && (b <= "9");
    endfunction

    function bit word_char(logic [7:0] b);
      return digit_char(b) || ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) ||
             (b == CH_USCORE);
    endfunction

    function out_t token(tok_class_t cls, logic [3:0] kw, logic [15:0] start,
                         logic [15:0] len, logic [7:0] sym);
      out_t r;
      r = '{token_class: cls, keyword_id: kw, start_pos: start, token_length: len,
            symbol_byte: sym, last_of_run: 1'b0};
      return r;
    endfunction

    // Finished word: keyword when length and text match, else constant or identifier
    function out_t word_token();
      bit same;
      tok_class_t cls;
      for (int k = 0; k < KW_COUNT; k++) begin
        if (tok_len == 16'(KW_LEN[k])) begin
          same = 1'b1;
          for (int j = 0; j < KW_LEN[k]; j++)
            if (word_head[j] != KW_TEXT[k][j]) same = 1'b0;
          if (same) return token(TOK_KEYWORD, 4'(k), tok_start, tok_len, 8'h00);
        end
      end
      if (digit_char(word_head[0])) cls = TOK_CONSTANT;
      else cls = TOK_IDENT;
      return token(cls, NOT_KEYWORD, tok_start, tok_len, 8'h00);
    endfunction

    function void open_token(lex_mode_e m, logic [15:0] at);
      mode      = m;
      tok_start = at;
      tok_len   = 16'd1;
      dot_seen  = 1'b0;
    endfunction

    function void lengthen();
      if (tok_len != LEN_MAX) tok_len++;
    endfunction

    // Advance the lexer by one accepted input beat and queue what it owes
    function void note_beat(in_t d);
      out_t       recs [$];
      logic [7:0] b;
      logic [15:0] at;
      bit         absorbed;
      logic [7:0] closer;
      b        = d.in_byte;
      at       = position;
      absorbed = 1'b0;
      if (d.end_of_input) begin
        // flush whatever is pending; position holds
        case (mode)
          LX_WORD:   recs.push_back(word_token());
          LX_HEADER: recs.push_back(token(TOK_HEADER, NOT_KEYWORD, tok_start, tok_len, 8'h00));
          LX_STRING: recs.push_back(token(TOK_STRING, NOT_KEYWORD, tok_start, tok_len, 8'h00));
          LX_CHAR:   recs.push_back(token(TOK_CHARLIT, NOT_KEYWORD, tok_start, tok_len, 8'h00));
          default: ;
        endcase
        mode = LX_IDLE;
      end else begin
        position = position + 16'd1;
        case (mode)
          LX_HEADER: begin
            // newline is swallowed and closes the header
            if (b == CH_NEWLINE) begin
              recs.push_back(token(TOK_HEADER, NOT_KEYWORD, tok_start, tok_len, 8'h00));
              mode = LX_IDLE;
            end else begin
              lengthen();
            end
          end
          LX_STRING, LX_CHAR: begin
            closer = (mode == LX_STRING) ? CH_DQUOTE : CH_SQUOTE;
            lengthen();
            if (b == closer) begin
              if (mode == LX_STRING)
                recs.push_back(token(TOK_STRING, NOT_KEYWORD, tok_start, tok_len, 8'h00));
              else
                recs.push_back(token(TOK_CHARLIT, NOT_KEYWORD, tok_start, tok_len, 8'h00));
              mode = LX_IDLE;
            end
          end
          default: begin
            // a word takes the byte or ends; an ending byte is then seen as from idle
            if (mode == LX_WORD) begin
              if (word_char(b) || ((b == CH_DOT) && !dot_seen)) begin
                if (tok_len < KW_MAX_LEN) word_head[tok_len] = b;
                if (b == CH_DOT) dot_seen = 1'b1;
                lengthen();
                absorbed = 1'b1;
              end else begin
                recs.push_back(word_token());
                mode = LX_IDLE;
              end
            end
            if (!absorbed) begin
              if (word_char(b)) begin
                open_token(LX_WORD, at);
                word_head[0] = b;
              end else if (in_text(OP_CHARS, b)) begin
                recs.push_back(token(TOK_OPERATOR, NOT_KEYWORD, at, 16'd1, b));
              end else if (b == CH_HASH) begin
                open_token(LX_HEADER, at);
              end else if (b == CH_DQUOTE) begin
                open_token(LX_STRING, at);
              end else if (in_text(SPECIAL_CHARS, b)) begin
                recs.push_back(token(TOK_SPECIAL, NOT_KEYWORD, at, 16'd1, b));
              end else if (b == CH_SQUOTE) begin
                open_token(LX_CHAR, at);
              end
            end
          end
        endcase
      end
      if (recs.size() > 0) recs[recs.size() - 1].last_of_run = 1'b1;
      foreach (recs[i]) token_q.push_back(recs[i]);
    endfunction

    task report(string what);
      errors++;
      $display("ERROR token check: %s", what);
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want, logic [15:0] at);
      if (got !== want)
        report($sformatf("token at %0d: %s is %0d, should be %0d", at, name, got, want));
    endtask

    task check_record(out_t got);
      out_t want;
      if (token_q.size() == 0) begin
        report($sformatf("record with none owed: class %0d start %0d length %0d",
                         got.token_class, got.start_pos, got.token_length));
        return;
      end
      want = token_q.pop_front();
      compare_field("token_class", got.token_class, want.token_class, want.start_pos);
      compare_field("keyword_id", got.keyword_id, want.keyword_id, want.start_pos);
      compare_field("start_pos", got.start_pos, want.start_pos, want.start_pos);
      compare_field("token_length", got.token_length, want.token_length, want.start_pos);
      compare_field("symbol_byte", got.symbol_byte, want.symbol_byte, want.start_pos);
      compare_field("last_of_run", got.last_of_run, want.last_of_run, want.start_pos);
    endtask

    task report_leftovers();
      out_t want;
      while (token_q.size() > 0) begin
        want = token_q.pop_front();
        report($sformatf("record never came: class %0d start %0d length %0d",
                         want.token_class, want.start_pos, want.token_length));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  lex_scoreboard sb;
  bit tx_calm;
  bit rx_calm;
  int beats_sent;

  c_subset_lexer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Send one input beat; valid stays up into the next call when there is no gap
  task automatic put_beat(input logic [7:0] b, input bit eoi);
    in_t d;
    int gap;
    d.in_byte      = b;
    d.end_of_input = eoi;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_beat(d);
    beats_sent++;
    if (beats_sent % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_beat(s[i], 1'b0);
  endtask

  // Hold the input side until the lexer has delivered everything owed
  task automatic drain_tokens();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [7:0] pick_char(input string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function automatic logic [7:0] word_byte();
    if ($urandom_range(0, 3) == 0) return pick_char(DIGITS);
    return pick_char(LETTERS);
  endfunction

  function automatic logic [7:0] any_but(input logic [7:0] x);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == x);
    return b;
  endfunction

  function automatic logic [7:0] boundary();
    case ($urandom_range(0, 2))
      0: return pick_char(lex_scoreboard::OP_CHARS);
      1: return pick_char(lex_scoreboard::SPECIAL_CHARS);
      default: return pick_char(GAPS);
    endcase
  endfunction

  // One random piece of C-like source, mostly well formed
  task automatic put_fragment();
    int pick;
    int n;
    int k;
    pick = $urandom_range(0, 99);
    n    = $urandom_range(0, 9);
    if (pick < 18) begin
      // keyword, now and then cut short or run on
      k = $urandom_range(0, KW_COUNT - 1);
      for (int j = 0; j < KW_LEN[k]; j++)
        if (!((j == KW_LEN[k] - 1) && (n == 0))) put_beat(KW_TEXT[k][j], 1'b0);
      if (n == 1) put_beat(word_byte(), 1'b0);
      if (n < 8) put_beat(boundary(), 1'b0);
    end else if (pick < 32) begin
      // identifier, dots now and then
      put_beat(pick_char(LETTERS), 1'b0);
      for (int j = 0; j < n; j++)
        put_beat(($urandom_range(0, 7) == 0) ? CH_DOT : word_byte(), 1'b0);
      if (n < 8) put_beat(boundary(), 1'b0);
    end else if (pick < 42) begin
      // numeric constant
      put_beat(pick_char(DIGITS), 1'b0);
      for (int j = 0; j < n; j++)
        put_beat(($urandom_range(0, 5) == 0) ? CH_DOT : pick_char(DIGITS), 1'b0);
      if (n < 8) put_beat(boundary(), 1'b0);
    end else if (pick < 52) begin
      put_beat(pick_char(lex_scoreboard::OP_CHARS), 1'b0);
    end else if (pick < 60) begin
      put_beat(pick_char(lex_scoreboard::SPECIAL_CHARS), 1'b0);
    end else if (pick < 72) begin
      put_beat(pick_char(GAPS), 1'b0);
    end else if (pick < 77) begin
      // header line, sometimes left open
      put_beat(CH_HASH, 1'b0);
      for (int j = 0; j < n; j++) put_beat(any_but(CH_NEWLINE), 1'b0);
      if (n != 9) put_beat(CH_NEWLINE, 1'b0);
    end else if (pick < 82) begin
      // string, any bytes inside, sometimes left open
      put_beat(CH_DQUOTE, 1'b0);
      for (int j = 0; j < n; j++) put_beat(any_but(CH_DQUOTE), 1'b0);
      if (n != 9) put_beat(CH_DQUOTE, 1'b0);
    end else if (pick < 86) begin
      put_beat(CH_SQUOTE, 1'b0);
      repeat ((n % 2) + 1) put_beat(any_but(CH_SQUOTE), 1'b0);
      if (n != 9) put_beat(CH_SQUOTE, 1'b0);
    end else if (pick < 95) begin
      put_beat(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      put_beat(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // Result side: random stalls, with calm stretches
  initial begin : result_side
    int stall;
    int taken;
    out_ready <= 1'b0;
    taken = 0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (taken % 48 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      stall = rx_calm ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_record(out_data);
      taken++;
    end
  end

  initial begin : stimulus
    int base;
    sb         = new();
    tx_calm    = 1'b0;
    beats_sent = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: word ended by a symbol, dotted words, quoted tokens, header,
    // ignored bytes, end of input inside a token and while idle
    put_text("if(a.b.c;7.5+'q'\"s\n\"#\n");
    put_beat(8'h00, 1'b0);
    put_beat(8'hFF, 1'b0);
    put_text("'z");
    put_beat(8'hA5, 1'b1);
    put_beat(8'h5A, 1'b1);
    drain_tokens();

    while (beats_sent < 950) put_fragment();
    drain_tokens();

    base = beats_sent;
    while (beats_sent < base + 930) put_fragment();
    put_beat(8'($urandom_range(0, 255)), 1'b1);
    in_valid <= 1'b0;

    for (int w = 0; (w < 2000) && (sb.pending() != 0); w++) @(posedge clk);
    repeat (20) @(posedge clk);
    sb.report_leftovers();
    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
